/* rtl/toeq_pkg.sv */
// Shared types and constants of the time ordered event queue.
package toeq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned TASK_W      = 16;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned OCC_W       = 5;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED     = 2'd0,
    ST_POPPED     = 2'd1,
    ST_FULL       = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  typedef struct packed {
    logic [TIME_W-1:0] evt_time;
    logic [TASK_W-1:0] task_id;
    logic [KIND_W-1:0] kind;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t ent;
  } cell_ctrl_t;

endpackage

/* rtl/toeq_if.sv */
// Request and response channel interfaces of the event queue.
interface toeq_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [toeq_pkg::TIME_W-1:0]   event_time;
  logic [toeq_pkg::TASK_W-1:0]   task_id;
  logic [toeq_pkg::KIND_W-1:0]   event_type;

  modport source (output valid, func, event_time, task_id, event_type, input ready);
  modport sink   (input valid, func, event_time, task_id, event_type, output ready);
endinterface

interface toeq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [toeq_pkg::TIME_W-1:0]   out_time;
  logic [toeq_pkg::TASK_W-1:0]   out_task_id;
  logic [toeq_pkg::KIND_W-1:0]   out_type;
  logic [toeq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_time, out_task_id, out_type, occupancy,
                  input ready);
  modport sink   (input valid, status, out_time, out_task_id, out_type, occupancy,
                  output ready);
endinterface

/* rtl/time_ordered_event_queue.sv */
// A result is registered and offered in the cycle after its request transfers.
// Throughput: one push or pop per cycle while req_i.ready is high; every cell shifts
// or holds in the same edge. The output register frees whenever its result transfers,
// so a stalled sink stops the request side only while a result is held.
// Reset clears the fill count and the output valid; slot contents are left as is.
// Slot i holds an entry while i is below the fill count; the earliest sits in slot 0.
module time_ordered_event_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  toeq_req_if.sink   req_i,
  toeq_rsp_if.source rsp_o
);

  localparam int unsigned N = toeq_pkg::QUEUE_DEPTH;

  logic [toeq_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       rsp_valid_q;
  logic [1:0]                 status_q;
  toeq_pkg::entry_t           rsp_ent_q;
  logic [toeq_pkg::CNT_W-1:0] rsp_cnt_q;

  logic                 xfer, is_full, is_empty;
  toeq_pkg::cell_ctrl_t ctrl;
  toeq_pkg::status_e    status_d;
  logic [N-1:0]         occ, stay, prev_stay;
  toeq_pkg::entry_t     ent [N];
  toeq_pkg::entry_t     prev_ent [N];
  toeq_pkg::entry_t     next_ent [N];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign xfer        = req_i.valid && req_i.ready;
  assign is_full     = (cnt_q == toeq_pkg::CNT_W'(N));
  assign is_empty    = (cnt_q == '0);

  always_comb begin
    ctrl.push         = xfer && (req_i.func == toeq_pkg::FUNC_PUSH) && !is_full;
    ctrl.pop          = xfer && (req_i.func == toeq_pkg::FUNC_POP) && !is_empty;
    ctrl.ent.evt_time = req_i.event_time;
    ctrl.ent.task_id  = req_i.task_id;
    ctrl.ent.kind     = req_i.event_type;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign occ[i] = (toeq_pkg::CNT_W'(i) < cnt_q);
    if (i == 0) begin : g_head
      assign prev_stay[i] = 1'b1;
      assign prev_ent[i]  = ctrl.ent;
    end else begin : g_body
      assign prev_stay[i] = stay[i-1];
      assign prev_ent[i]  = ent[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_ent[i] = ent[i];
    end else begin : g_link
      assign next_ent[i] = ent[i+1];
    end
    toeq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .prev_stay_i (prev_stay[i]),
      .prev_ent_i  (prev_ent[i]),
      .next_ent_i  (next_ent[i]),
      .ent_o       (ent[i]),
      .stay_o      (stay[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.push) begin
      cnt_d = cnt_q + toeq_pkg::CNT_W'(1);
    end else if (ctrl.pop) begin
      cnt_d = cnt_q - toeq_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    if (req_i.func == toeq_pkg::FUNC_PUSH) begin
      status_d = is_full ? toeq_pkg::ST_FULL : toeq_pkg::ST_PUSHED;
    end else begin
      status_d = is_empty ? toeq_pkg::ST_EMPTY : toeq_pkg::ST_POPPED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (xfer) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      status_q  <= status_d;
      rsp_ent_q <= ctrl.pop ? ent[0] : '0;
      rsp_cnt_q <= cnt_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.out_time    = rsp_ent_q.evt_time;
  assign rsp_o.out_task_id = rsp_ent_q.task_id;
  assign rsp_o.out_type    = rsp_ent_q.kind;
  assign rsp_o.occupancy   = toeq_pkg::OCC_W'(rsp_cnt_q);

endmodule

/* rtl/toeq_cell.sv */
// One slot of the sorted shift-register queue.
module toeq_cell (
  input  logic                 clk_i,
  input  toeq_pkg::cell_ctrl_t ctrl_i,
  input  logic                 occ_i,
  input  logic                 prev_stay_i,
  input  toeq_pkg::entry_t     prev_ent_i,
  input  toeq_pkg::entry_t     next_ent_i,
  output toeq_pkg::entry_t     ent_o,
  output logic                 stay_o
);

  toeq_pkg::entry_t ent_q, ent_d;

  assign stay_o = occ_i && (ent_q.evt_time <= ctrl_i.ent.evt_time);
  assign ent_o  = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.push) begin
      if (stay_o) begin
        ent_d = ent_q;
      end else if (prev_stay_i) begin
        ent_d = ctrl_i.ent;
      end else begin
        ent_d = prev_ent_i;
      end
    end else if (ctrl_i.pop) begin
      ent_d = next_ent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule
